/* rtl/bsvfb_pkg.sv */
`timescale 1ns / 1ps
package bsvfb_pkg;

  localparam int unsigned AddrW = 17;

  localparam logic [13:0] VideoByteLimit = 14'h3000;
  localparam logic [5:0]  RunMax         = 6'd63;

  localparam int unsigned IorqBit = 2;
  localparam int unsigned CasBit  = 1;
  localparam int unsigned WrBit   = 0;

  localparam int unsigned BrightBit = 6;
  localparam int unsigned FlashBit  = 7;

  localparam logic [2:0] ColourMask  = 3'h7;
  localparam logic [3:0] MonoInk     = 4'd0;
  localparam logic [3:0] MonoPaper   = 4'd7;

  localparam logic [5:0] CfgResetCasMin = 6'd3;
  localparam logic [5:0] CfgResetCasMax = 6'd5;
  localparam logic [5:0] CfgResetIoMin  = 6'd6;
  localparam logic [5:0] CfgResetIoMax  = 6'd39;
  localparam logic [5:0] CfgResetSettle = 6'd50;

  typedef enum logic [2:0] {
    RegBitRev   = 3'd0,
    RegColourEn = 3'd1,
    RegCasMin   = 3'd2,
    RegCasMax   = 3'd3,
    RegIoMin    = 3'd4,
    RegIoMax    = 3'd5,
    RegSettle   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic       bit_rev;
    logic       colour_en;
    logic [5:0] cas_min;
    logic [5:0] cas_max;
    logic [5:0] io_min;
    logic [5:0] io_max;
    logic [5:0] settle;
  } cfg_t;

  // One queued sample: an optional border write and an optional 8-pixel group.
  typedef struct packed {
    logic             border_vld;
    logic [AddrW-1:0] border_addr;
    logic [3:0]       border_colour;
    logic             pix_vld;
    logic [AddrW-1:0] pix_base;
    logic [7:0]       pix_mask;
    logic [3:0]       ink;
    logic [3:0]       paper;
  } job_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[7-k] = v[k];
    end
    return r;
  endfunction

  // Bright black stays black.
  function automatic logic [3:0] colour_of(input logic [2:0] col, input logic bright);
    logic [3:0] c;
    if (col == 3'd0) begin
      c = 4'd0;
    end else begin
      c = {bright, col & ColourMask};
    end
    return c;
  endfunction

endpackage

/* rtl/bsvfb_front.sv */
`timescale 1ns / 1ps
module bsvfb_front #(
  parameter int unsigned SCREEN_WIDTH  = 320,
  parameter int unsigned SCREEN_HEIGHT = 256,
  parameter int unsigned BORDER_WIDTH  = 32,
  parameter int unsigned BORDER_HEIGHT = 32,
  parameter int unsigned FLASH_FRAMES  = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bsvfb_pkg::cfg_t   cfg_i,
  input  logic              accept_i,
  input  logic              start_of_frame_i,
  input  logic [15:0]       frame_number_i,
  input  logic [15:0]       bus_sample_i,
  output logic              push_o,
  output bsvfb_pkg::job_t   job_o
);

  localparam int unsigned EndX = (SCREEN_WIDTH > BORDER_WIDTH) ?
                                 SCREEN_WIDTH - BORDER_WIDTH : 0;
  localparam int unsigned EndY = (SCREEN_HEIGHT > BORDER_HEIGHT) ?
                                 SCREEN_HEIGHT - BORDER_HEIGHT : 0;
  localparam logic [9:0] EndXC = 10'(EndX);
  localparam logic [9:0] EndYC = 10'(EndY);
  localparam logic [9:0] ScrWC = 10'(SCREEN_WIDTH);
  localparam logic [9:0] ScrHC = 10'(SCREEN_HEIGHT);
  localparam logic [9:0] BrdWC = 10'(BORDER_WIDTH);
  localparam logic [9:0] BrdHC = 10'(BORDER_HEIGHT);

  // frame_number / FLASH_FRAMES by reciprocal multiply (exact for 16-bit input)
  localparam int unsigned FlashShift = 16 + $clog2(FLASH_FRAMES);
  localparam logic [16:0] FlashMul   =
      17'(((64'(1) << FlashShift) + 64'(FLASH_FRAMES) - 64'(1)) / 64'(FLASH_FRAMES));

  typedef struct packed {
    logic [5:0]  sidx;
    logic [5:0]  cas_run;
    logic [5:0]  io_run;
    logic        cas_seen;
    logic [7:0]  last_cas;
    logic [7:0]  last_io;
    logic [13:0] vcount;
    logic        nip;
    logic [7:0]  pix_byte;
    logic [7:0]  attr_byte;
    logic        pair;
    logic [8:0]  bx;
    logic [8:0]  by;
    logic [8:0]  px;
    logic [8:0]  py;
    logic        bdone;
    logic        pdone;
  } fr_state_t;

  localparam fr_state_t FrameReset = '{
    sidx: 6'd0, cas_run: 6'd0, io_run: 6'd0, cas_seen: 1'b0,
    last_cas: 8'd0, last_io: 8'd0, vcount: 14'd0, nip: 1'b1,
    pix_byte: 8'd0, attr_byte: 8'd0, pair: 1'b0,
    bx: 9'd0, by: 9'd0, px: 9'(BORDER_WIDTH), py: 9'(BORDER_HEIGHT),
    bdone: 1'b0, pdone: 1'b0
  };

  fr_state_t   st_q, st_d, cur;
  logic [7:0]  border_q, border_d;
  logic        flash_q, flash_d;

  logic [7:0]  data;
  logic        cas, iowr, done;
  logic [32:0] flash_prod;
  logic [9:0]  bx_inc, by_inc, px_inc, py_inc;
  logic [19:0] border_lin, pix_lin;
  logic        in_border, inv, set_bit;
  logic [7:0]  attr_v;
  logic [3:0]  ink_c, paper_c;

  assign data       = bus_sample_i[15:8];
  assign cas        = !bus_sample_i[bsvfb_pkg::CasBit];
  assign iowr       = !bus_sample_i[bsvfb_pkg::IorqBit] && !bus_sample_i[bsvfb_pkg::WrBit];
  assign flash_prod = 33'(frame_number_i) * 33'(FlashMul);

  always_comb begin
    cur       = start_of_frame_i ? FrameReset : st_q;
    flash_d   = start_of_frame_i ? flash_prod[FlashShift] : flash_q;
    done      = cur.bdone && cur.pdone;
    st_d      = cur;
    border_d  = border_q;
    job_o     = '0;
    bx_inc    = '0;
    by_inc    = '0;
    px_inc    = '0;
    py_inc    = '0;
    border_lin = '0;
    pix_lin   = '0;
    in_border = 1'b0;
    inv       = 1'b0;
    set_bit   = 1'b0;
    attr_v    = '0;
    ink_c     = '0;
    paper_c   = '0;

    if (!done) begin
      // video fetch
      if (cur.sidx > cfg_i.settle) begin
        st_d.cas_seen = cur.cas_seen || !cas;
        if (st_d.cas_seen && cas) begin
          st_d.last_cas = data;
          if (cur.cas_run < bsvfb_pkg::RunMax) begin
            st_d.cas_run = cur.cas_run + 6'd1;
          end
        end else begin
          if (cur.cas_run >= cfg_i.cas_min && cur.cas_run <= cfg_i.cas_max &&
              cur.vcount < bsvfb_pkg::VideoByteLimit) begin
            st_d.vcount = cur.vcount + 14'd1;
            if (cur.nip) begin
              st_d.pix_byte = cur.last_cas;
            end else begin
              st_d.attr_byte = cfg_i.bit_rev ? bsvfb_pkg::rev8(cur.last_cas) : cur.last_cas;
              st_d.pair      = 1'b1;
            end
            st_d.nip = !cur.nip;
          end
          st_d.cas_run = 6'd0;
        end
      end
      if (cur.sidx < bsvfb_pkg::RunMax) begin
        st_d.sidx = cur.sidx + 6'd1;
      end

      // border write
      if (iowr) begin
        st_d.last_io = data;
        if (cur.io_run < bsvfb_pkg::RunMax) begin
          st_d.io_run = cur.io_run + 6'd1;
        end
      end else begin
        if (cur.io_run >= cfg_i.io_min && cur.io_run <= cfg_i.io_max) begin
          border_d = cfg_i.bit_rev ? bsvfb_pkg::rev8(cur.last_io) : cur.last_io;
        end
        st_d.io_run = 6'd0;
      end

      // border raster
      if (!cur.bdone) begin
        in_border = ({1'b0, cur.by} < BrdHC) || ({1'b0, cur.by} >= EndYC) ||
                    ({1'b0, cur.bx} < BrdWC) || ({1'b0, cur.bx} >= EndXC);
        border_lin = 20'(cur.by) * 20'(ScrWC) + 20'(cur.bx);
        job_o.border_vld    = in_border;
        job_o.border_addr   = border_lin[bsvfb_pkg::AddrW-1:0];
        job_o.border_colour = bsvfb_pkg::colour_of(border_d[2:0],
                                                   border_d[bsvfb_pkg::BrightBit]);
        bx_inc = {1'b0, cur.bx} + 10'd1;
        if (bx_inc >= ScrWC) begin
          st_d.bx = 9'd0;
          by_inc  = {1'b0, cur.by} + 10'd1;
          st_d.by = by_inc[8:0];
          if (by_inc >= ScrHC) begin
            st_d.bdone = 1'b1;
          end
        end else begin
          st_d.bx = bx_inc[8:0];
        end
      end

      // pixel group
      if (st_d.pair && !cur.pdone) begin
        attr_v  = st_d.attr_byte;
        inv     = attr_v[bsvfb_pkg::FlashBit] && flash_d;
        ink_c   = bsvfb_pkg::colour_of(attr_v[2:0], attr_v[bsvfb_pkg::BrightBit]);
        paper_c = bsvfb_pkg::colour_of(attr_v[5:3], attr_v[bsvfb_pkg::BrightBit]);
        pix_lin = 20'(cur.py) * 20'(ScrWC) + 20'(cur.px);
        job_o.pix_vld  = 1'b1;
        job_o.pix_base = pix_lin[bsvfb_pkg::AddrW-1:0];
        job_o.ink      = cfg_i.colour_en ? ink_c : bsvfb_pkg::MonoInk;
        job_o.paper    = cfg_i.colour_en ? paper_c : bsvfb_pkg::MonoPaper;
        for (int k = 0; k < 8; k++) begin
          set_bit = cfg_i.bit_rev ? st_d.pix_byte[k] : st_d.pix_byte[7-k];
          job_o.pix_mask[k] = set_bit ^ inv;
        end
        st_d.pair = 1'b0;
        px_inc = {1'b0, cur.px} + 10'd8;
        if (px_inc >= EndXC) begin
          st_d.px = 9'(BORDER_WIDTH);
          py_inc  = {1'b0, cur.py} + 10'd1;
          st_d.py = py_inc[8:0];
          if (py_inc >= EndYC) begin
            st_d.pdone = 1'b1;
          end
        end else begin
          st_d.px = px_inc[8:0];
        end
      end
    end
  end

  assign push_o = accept_i && (job_o.border_vld || job_o.pix_vld);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= FrameReset;
      border_q <= 8'd0;
      flash_q  <= 1'b0;
    end else if (accept_i) begin
      st_q     <= st_d;
      border_q <= border_d;
      flash_q  <= flash_d;
    end
  end

  a_vcount_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.vcount <= bsvfb_pkg::VideoByteLimit)
    else $error("video byte count beyond limit");

endmodule

/* rtl/bsvfb_fifo.sv */
`timescale 1ns / 1ps
module bsvfb_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bsvfb_pkg::job_t push_data_i,
  input  logic            pop_i,
  output bsvfb_pkg::job_t head_o,
  output logic            empty_o,
  output logic            full_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  bsvfb_pkg::job_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign head_o  = mem_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntFull);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue pop while empty");

  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + CntW'(1))
    else $error("queue count lost a push");

endmodule

/* rtl/bsvfb_back.sv */
`timescale 1ns / 1ps
module bsvfb_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bsvfb_pkg::job_t                   head_i,
  input  logic                              empty_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [bsvfb_pkg::AddrW-1:0]       write_address_o,
  output logic [3:0]                        colour_index_o,
  output logic                              last_o
);

  localparam logic [3:0] StepBorder   = 4'd0;
  localparam logic [3:0] StepFirstPix = 4'd1;
  localparam logic [3:0] StepLast     = 4'd8;

  bsvfb_pkg::job_t job_q, job_d;
  logic            busy_q, busy_d;
  logic [3:0]      step_q, step_d;
  logic            out_valid_q, out_valid_d;
  logic [bsvfb_pkg::AddrW-1:0] addr_q, addr_d;
  logic [3:0]      colour_q, colour_d;
  logic            last_q, last_d;
  logic            can_adv, cur_last, load;
  logic [2:0]      k;
  logic [3:0]      k_wide;

  always_comb begin
    job_d       = job_q;
    busy_d      = busy_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    addr_d      = addr_q;
    colour_d    = colour_q;
    last_d      = last_q;
    can_adv     = !out_valid_q || !out_stall_i;
    cur_last    = (step_q == StepLast) || (step_q == StepBorder && !job_q.pix_vld);
    k_wide      = step_q - StepFirstPix;
    k           = k_wide[2:0];
    load        = 1'b0;

    if (can_adv) begin
      out_valid_d = busy_q;
    end
    if (!busy_q) begin
      load = 1'b1;
    end else if (can_adv) begin
      if (step_q == StepBorder) begin
        addr_d   = job_q.border_addr;
        colour_d = job_q.border_colour;
      end else begin
        addr_d   = job_q.pix_base + bsvfb_pkg::AddrW'(k);
        colour_d = job_q.pix_mask[k] ? job_q.ink : job_q.paper;
      end
      last_d = cur_last;
      step_d = step_q + 4'd1;
      load   = cur_last;
    end

    pop_o = load && !empty_i;
    if (load) begin
      busy_d = !empty_i;
      job_d  = head_i;
      step_d = head_i.border_vld ? StepBorder : StepFirstPix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= StepBorder;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q    <= job_d;
    addr_q   <= addr_d;
    colour_q <= colour_d;
    last_q   <= last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign write_address_o = addr_q;
  assign colour_index_o  = colour_q;
  assign last_o          = last_q;

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> step_q <= StepLast)
    else $error("write step out of range");

  a_burst_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !last_q) |=> out_valid_q)
    else $error("gap inside a write burst");

endmodule

/* rtl/bus_sniff_video_frame_builder.sv */
`timescale 1ns / 1ps
// Path: a sample's writes pass through the sample queue, the back-end job register and
// the output register before they are presented; a busy back end or a stall can hold them.
// Throughput: one sample per cycle at the input while the queue is not full; one write per
// cycle at the output while out_stall_i is low, so a sample with a pixel group holds the write
// port for up to nine writes, and the sample queue (QUEUE_DEPTH entries) absorbs bursts.
// Reset: asynchronous, active low; clears frame state, border byte, and registers to defaults.
module bus_sniff_video_frame_builder #(
  parameter int unsigned SCREEN_WIDTH  = 320,
  parameter int unsigned SCREEN_HEIGHT = 256,
  parameter int unsigned BORDER_WIDTH  = 32,
  parameter int unsigned BORDER_HEIGHT = 32,
  parameter int unsigned FLASH_FRAMES  = 16,
  parameter int unsigned QUEUE_DEPTH   = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        start_of_frame_i,
  input  logic [15:0] frame_number_i,
  input  logic [15:0] bus_sample_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [16:0] write_address_o,
  output logic [3:0]  colour_index_o,
  output logic        last_o
);

  bsvfb_pkg::cfg_t     cfg_q, cfg_d;
  bsvfb_pkg::reg_idx_e reg_idx;
  bsvfb_pkg::job_t     job, head;
  logic                cfg_wr, accept, push, pop, empty, full;

  assign pready  = 1'b1;
  assign reg_idx = bsvfb_pkg::reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    cfg_d  = cfg_q;
    prdata = 32'd0;
    case (reg_idx)
      bsvfb_pkg::RegBitRev: begin
        prdata = 32'(cfg_q.bit_rev);
        if (cfg_wr) cfg_d.bit_rev = pwdata[0];
      end
      bsvfb_pkg::RegColourEn: begin
        prdata = 32'(cfg_q.colour_en);
        if (cfg_wr) cfg_d.colour_en = pwdata[0];
      end
      bsvfb_pkg::RegCasMin: begin
        prdata = 32'(cfg_q.cas_min);
        if (cfg_wr) cfg_d.cas_min = pwdata[5:0];
      end
      bsvfb_pkg::RegCasMax: begin
        prdata = 32'(cfg_q.cas_max);
        if (cfg_wr) cfg_d.cas_max = pwdata[5:0];
      end
      bsvfb_pkg::RegIoMin: begin
        prdata = 32'(cfg_q.io_min);
        if (cfg_wr) cfg_d.io_min = pwdata[5:0];
      end
      bsvfb_pkg::RegIoMax: begin
        prdata = 32'(cfg_q.io_max);
        if (cfg_wr) cfg_d.io_max = pwdata[5:0];
      end
      bsvfb_pkg::RegSettle: begin
        prdata = 32'(cfg_q.settle);
        if (cfg_wr) cfg_d.settle = pwdata[5:0];
      end
      default: begin
        prdata = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_rev   <= 1'b0;
      cfg_q.colour_en <= 1'b1;
      cfg_q.cas_min   <= bsvfb_pkg::CfgResetCasMin;
      cfg_q.cas_max   <= bsvfb_pkg::CfgResetCasMax;
      cfg_q.io_min    <= bsvfb_pkg::CfgResetIoMin;
      cfg_q.io_max    <= bsvfb_pkg::CfgResetIoMax;
      cfg_q.settle    <= bsvfb_pkg::CfgResetSettle;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  bsvfb_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .BORDER_WIDTH  (BORDER_WIDTH),
    .BORDER_HEIGHT (BORDER_HEIGHT),
    .FLASH_FRAMES  (FLASH_FRAMES)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .accept_i         (accept),
    .start_of_frame_i (start_of_frame_i),
    .frame_number_i   (frame_number_i),
    .bus_sample_i     (bus_sample_i),
    .push_o           (push),
    .job_o            (job)
  );

  bsvfb_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (job),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty),
    .full_o      (full)
  );

  bsvfb_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .empty_i         (empty),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .write_address_o (write_address_o),
    .colour_index_o  (colour_index_o),
    .last_o          (last_o)
  );

endmodule

/* tb/bus_sniff_video_frame_builder_tb.sv */
`timescale 1ns / 1ps
module bus_sniff_video_frame_builder_tb;

  localparam int unsigned ScreenW     = 320;
  localparam int unsigned ScreenH     = 256;
  localparam int unsigned BorderW     = 32;
  localparam int unsigned BorderH     = 32;
  localparam int unsigned FlashFrames = 16;
  localparam int unsigned EndX = (ScreenW > BorderW) ? ScreenW - BorderW : 0;
  localparam int unsigned EndY = (ScreenH > BorderH) ? ScreenH - BorderH : 0;
  localparam int unsigned FinalLen = 50;
  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned NumPhases = 5;

  localparam logic [2:0] RegNone = 3'd7;
  // bus control bits: IORQ, CAS, WR (active low)
  localparam logic [2:0] CtlIdle = 3'b111;
  localparam logic [2:0] CtlCas  = 3'b101;
  localparam logic [2:0] CtlIoWr = 3'b010;

  typedef struct packed {
    logic [16:0] addr;
    logic [3:0]  colour;
    logic        last;
  } fb_write_t;

  typedef struct packed {
    logic        sof;
    logic [15:0] fn;
    logic [15:0] bus;
    logic        typed;
    logic [16:0] addr;
    logic [3:0]  colour;
  } probe_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        in_valid_i, in_stall_o;
  logic        start_of_frame_i;
  logic [15:0] frame_number_i, bus_sample_i;
  logic        out_valid_o, out_stall_i;
  logic [16:0] write_address_o;
  logic [3:0]  colour_index_o;
  logic        last_o;

  bus_sniff_video_frame_builder #(
    .SCREEN_WIDTH (ScreenW),
    .SCREEN_HEIGHT(ScreenH),
    .BORDER_WIDTH (BorderW),
    .BORDER_HEIGHT(BorderH),
    .FLASH_FRAMES (FlashFrames)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .start_of_frame_i(start_of_frame_i),
    .frame_number_i  (frame_number_i),
    .bus_sample_i    (bus_sample_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .write_address_o (write_address_o),
    .colour_index_o  (colour_index_o),
    .last_o          (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  fb_write_t   fb_writes[$];
  int          errors = 0;
  int unsigned cycles = 0;
  bit          idle_on = 1'b1;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  bsvfb_pkg::cfg_t shadow;
  logic [5:0]  smp_idx, cas_len, io_len;
  logic        cas_armed;
  logic [7:0]  cas_data, io_data, border_byte, pix_byte, attr_byte;
  logic [13:0] vid_bytes;
  logic        want_pixel, pair_ready, border_full, pixels_full, flash_on;
  int unsigned bx, by, px, py;

  function automatic logic [7:0] flip8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[k] = v[7-k];
    end
    return r;
  endfunction

  // bright black stays black
  function automatic logic [3:0] shade(input logic [2:0] col, input logic bright);
    return (col == 3'd0) ? 4'd0 : {bright, col};
  endfunction

  function automatic logic [15:0] bus_word(input logic [2:0] ctl);
    return {8'($urandom), 5'($urandom), ctl};
  endfunction

  function automatic int pulse_len(input logic [5:0] lo, input logic [5:0] hi,
                                   input bit long_runs);
    int a, b;
    a = (lo == 6'd0) ? 1 : int'(lo);
    b = int'(hi);
    if (long_runs) begin
      return $urandom_range(60, 70);
    end
    if (a > b || $urandom_range(0, 3) == 0) begin
      return $urandom_range(1, 8);
    end
    if (b > a + 3) begin
      b = a + 3;
    end
    return $urandom_range(a, b);
  endfunction

  function automatic logic [5:0] cfg_field(input bsvfb_pkg::cfg_t c, input logic [2:0] idx);
    case (idx)
      bsvfb_pkg::RegBitRev:   return {5'd0, c.bit_rev};
      bsvfb_pkg::RegColourEn: return {5'd0, c.colour_en};
      bsvfb_pkg::RegCasMin:   return c.cas_min;
      bsvfb_pkg::RegCasMax:   return c.cas_max;
      bsvfb_pkg::RegIoMin:    return c.io_min;
      bsvfb_pkg::RegIoMax:    return c.io_max;
      bsvfb_pkg::RegSettle:   return c.settle;
      default:                return 6'd0;
    endcase
  endfunction

  task automatic clear_frame();
    smp_idx = '0; cas_len = '0; io_len = '0; cas_armed = 1'b0;
    cas_data = '0; io_data = '0; vid_bytes = '0; want_pixel = 1'b1;
    pix_byte = '0; attr_byte = '0; pair_ready = 1'b0;
    bx = 0; by = 0; px = BorderW & 'h1FF; py = BorderH & 'h1FF;
    border_full = 1'b0; pixels_full = 1'b0;
  endtask

  task automatic predict_writes(input logic sof, input logic [15:0] fn,
                                input logic [15:0] bus, input bit keep);
    fb_write_t  burst [9];
    int         n;
    logic [7:0] data;
    logic       cas, iowr, lit, inv;
    logic [3:0] ink, paper, c;
    int unsigned base;
    n = 0;
    data = bus[15:8];
    cas = !bus[bsvfb_pkg::CasBit];
    iowr = !bus[bsvfb_pkg::IorqBit] && !bus[bsvfb_pkg::WrBit];
    if (sof) begin
      clear_frame();
      flash_on = ((fn / FlashFrames) % 2) != 0;
    end
    if (border_full && pixels_full) begin
      return;
    end
    if (smp_idx > shadow.settle) begin
      if (!cas_armed) begin
        cas_armed = !cas;
      end
      if (cas_armed && cas) begin
        cas_data = data;
        if (cas_len < bsvfb_pkg::RunMax) cas_len++;
      end else begin
        if (cas_len >= shadow.cas_min && cas_len <= shadow.cas_max &&
            vid_bytes < bsvfb_pkg::VideoByteLimit) begin
          vid_bytes++;
          if (want_pixel) begin
            pix_byte = cas_data;
          end else begin
            attr_byte = shadow.bit_rev ? flip8(cas_data) : cas_data;
            pair_ready = 1'b1;
          end
          want_pixel = !want_pixel;
        end
        cas_len = '0;
      end
    end
    if (smp_idx < bsvfb_pkg::RunMax) smp_idx++;
    if (iowr) begin
      io_data = data;
      if (io_len < bsvfb_pkg::RunMax) io_len++;
    end else begin
      if (io_len >= shadow.io_min && io_len <= shadow.io_max) begin
        border_byte = shadow.bit_rev ? flip8(io_data) : io_data;
      end
      io_len = '0;
    end
    if (!border_full) begin
      if (bx < BorderW || bx >= EndX || by < BorderH || by >= EndY) begin
        burst[n] = '{17'(by * ScreenW + bx),
                     shade(border_byte[2:0], border_byte[bsvfb_pkg::BrightBit]), 1'b0};
        n++;
      end
      bx++;
      if (bx >= ScreenW) begin
        bx = 0;
        by++;
        if (by >= ScreenH) border_full = 1'b1;
      end
      by &= 'h1FF;
    end
    if (pair_ready && !pixels_full) begin
      ink = shade(attr_byte[2:0], attr_byte[bsvfb_pkg::BrightBit]);
      paper = shade(attr_byte[5:3], attr_byte[bsvfb_pkg::BrightBit]);
      inv = attr_byte[bsvfb_pkg::FlashBit] && flash_on;
      base = py * ScreenW + px;
      pair_ready = 1'b0;
      for (int k = 0; k < 8; k++) begin
        lit = (shadow.bit_rev ? pix_byte[k] : pix_byte[7-k]) ^ inv;
        if (shadow.colour_en) c = lit ? ink : paper;
        else c = lit ? bsvfb_pkg::MonoInk : bsvfb_pkg::MonoPaper;
        burst[n] = '{17'(base + k), c, 1'b0};
        n++;
      end
      px += 8;
      if (px >= EndX) begin
        px = BorderW;
        py++;
        if (py >= EndY) pixels_full = 1'b1;
      end
      px &= 'h1FF;
      py &= 'h1FF;
    end
    if (keep) begin
      for (int i = 0; i < n; i++) begin
        burst[i].last = (i == n - 1);
        fb_writes.push_back(burst[i]);
      end
    end
  endtask

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic push_sample(input logic sof, input logic [15:0] fn,
                             input logic [15:0] bus, input bit keep);
    if (idle_on && !calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    start_of_frame_i <= sof;
    frame_number_i <= fn;
    bus_sample_i <= bus;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_writes(sof, fn, bus, keep);
    @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apb_read(input logic [2:0] idx, output logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    val = prdata;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic verify_cfg();
    logic [31:0] rd;
    for (int i = bsvfb_pkg::RegBitRev; i <= bsvfb_pkg::RegSettle; i++) begin
      apb_read(3'(i), rd);
      if (rd != 32'(cfg_field(shadow, 3'(i)))) begin
        errors++;
        $display("%0t reg %0d: expected %h actual %h", $realtime, i,
                 32'(cfg_field(shadow, 3'(i))), rd);
      end
    end
  endtask

  task automatic apply_cfg(input bsvfb_pkg::cfg_t c);
    apb_write(RegNone, $urandom);
    for (int i = bsvfb_pkg::RegBitRev; i <= bsvfb_pkg::RegSettle; i++) begin
      apb_write(3'(i), {26'($urandom), cfg_field(c, 3'(i))});
    end
    shadow = c;
    verify_cfg();
  endtask

  // nothing expected and the pipeline drained of samples without writes
  task automatic settle_pipe();
    in_valid_i <= 1'b0;
    while (fb_writes.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic run_phase(input int n_items, input bit long_runs);
    int         sent, len, gap, sel;
    logic [2:0] ctl;
    push_sample(1'b1, 16'($urandom), bus_word(CtlIdle), 1'b1);
    sent = 1;
    while (sent < n_items) begin
      sel = $urandom_range(0, 15);
      if (sel == 0) begin
        push_sample(1'b1, 16'($urandom), bus_word(CtlIdle), 1'b1);
        sent++;
      end else if (sel < 4) begin
        push_sample(1'b0, 16'($urandom), 16'($urandom), 1'b1);
        sent++;
      end else begin
        if (sel < 11) begin
          ctl = CtlCas;
          len = pulse_len(shadow.cas_min, shadow.cas_max, long_runs);
        end else begin
          ctl = CtlIoWr;
          len = pulse_len(shadow.io_min, shadow.io_max, long_runs);
        end
        gap = $urandom_range(1, 2);
        for (int i = 0; i < len + gap; i++) begin
          push_sample(1'b0, 16'($urandom), bus_word(i < len ? ctl : CtlIdle), 1'b1);
        end
        sent += len + gap;
      end
    end
  endtask

  const probe_t probe_rows [23] = '{
    '{1'b1, 16'hFFFF, 16'hFFFF,               1'b1, 17'd0, 4'd0},
    '{1'b0, 16'h0000, {8'h47, 5'h1F, CtlIoWr}, 1'b0, 17'd0, 4'd0},
    '{1'b0, 16'h0000, {8'hFF, 5'h1F, CtlIdle}, 1'b0, 17'd0, 4'd0},
    '{1'b0, 16'h0000, {8'hA5, 5'h1F, CtlCas},  1'b0, 17'd0, 4'd0},
    '{1'b0, 16'h0000, {8'hFF, 5'h1F, CtlIdle}, 1'b0, 17'd0, 4'd0},
    '{1'b0, 16'h0000, {8'hE1, 5'h1F, CtlCas},  1'b0, 17'd0, 4'd0},
    '{1'b0, 16'h0000, {8'hFF, 5'h1F, CtlIdle}, 1'b0, 17'd0, 4'd0},
    '{1'b0, 16'h0000, 16'h0000,               1'b0, 17'd0, 4'd0},
    '{1'b0, 16'h0000, 16'h0000,               1'b0, 17'd0, 4'd0},
    '{1'b0, 16'h0000, 16'h0000,               1'b0, 17'd0, 4'd0},
    '{1'b0, 16'h0000, {8'hFF, 5'h1F, CtlIdle}, 1'b0, 17'd0, 4'd0},
    '{1'b0, 16'h0000, {8'h3C, 5'h1F, CtlCas},  1'b0, 17'd0, 4'd0},
    '{1'b0, 16'h0000, {8'h3C, 5'h1F, CtlCas},  1'b0, 17'd0, 4'd0},
    '{1'b0, 16'h0000, {8'hFF, 5'h1F, CtlIdle}, 1'b0, 17'd0, 4'd0},
    '{1'b0, 16'h0000, {8'hFF, 5'h1F, CtlCas},  1'b0, 17'd0, 4'd0},
    '{1'b0, 16'h0000, {8'hFF, 5'h1F, CtlIdle}, 1'b0, 17'd0, 4'd0},
    '{1'b0, 16'h0000, {8'h00, 5'h1F, CtlCas},  1'b0, 17'd0, 4'd0},
    '{1'b0, 16'h0000, {8'hFF, 5'h1F, CtlIdle}, 1'b0, 17'd0, 4'd0},
    '{1'b0, 16'h0000, {8'h40, 5'h1F, CtlCas},  1'b0, 17'd0, 4'd0},
    '{1'b0, 16'h0000, {8'hFF, 5'h1F, CtlIdle}, 1'b0, 17'd0, 4'd0},
    '{1'b1, 16'h000F, {8'hFF, 5'h1F, CtlIdle}, 1'b1, 17'd0, 4'hF},
    '{1'b0, 16'h0000, 16'hFFFE,               1'b0, 17'd0, 4'd0},
    '{1'b0, 16'h0000, 16'hFFFB,               1'b0, 17'd0, 4'd0}
  };

  const bsvfb_pkg::cfg_t phase_cfg [NumPhases] = '{
    '{1'b0, 1'b1, bsvfb_pkg::CfgResetCasMin, bsvfb_pkg::CfgResetCasMax,
      bsvfb_pkg::CfgResetIoMin, bsvfb_pkg::CfgResetIoMax, bsvfb_pkg::CfgResetSettle},
    '{1'b1, 1'b0, 6'd0,  6'd63, 6'd0,  6'd63, 6'd0},
    '{1'b1, 1'b1, 6'd63, 6'd63, 6'd63, 6'd63, 6'd5},
    '{1'b0, 1'b0, 6'd5,  6'd2,  6'd40, 6'd1,  6'd63},
    '{1'b0, 1'b1, 6'd1,  6'd1,  6'd1,  6'd1,  6'd1}
  };
  const int phase_len [NumPhases] = '{50, 25, 45, 20, 25};
  const bit phase_long [NumPhases] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

  // receiver: random stall bursts, calm stretches, one long hold-off
  initial begin
    int left;
    left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 199) == 0) calm = !calm;
      if (left > 0) begin
        left--;
      end else if (hold_req) begin
        left = 300;
        hold_req = 1'b0;
      end else if (idle_on && !calm && $urandom_range(0, 4) == 0) begin
        left = $urandom_range(1, 9);
      end
      out_stall_i <= (left > 0);
    end
  end

  always @(posedge clk_i) begin
    fb_write_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (fb_writes.size() == 0) begin
        errors++;
        $display("%0t unexpected write: expected none actual addr %h colour %h last %b",
                 $realtime, write_address_o, colour_index_o, last_o);
      end else begin
        want = fb_writes.pop_front();
        if (want.addr !== write_address_o) begin
          errors++;
          $display("%0t write_address: expected %h actual %h",
                   $realtime, want.addr, write_address_o);
        end
        if (want.colour !== colour_index_o) begin
          errors++;
          $display("%0t colour_index: expected %h actual %h",
                   $realtime, want.colour, colour_index_o);
        end
        if (want.last !== last_o) begin
          errors++;
          $display("%0t last: expected %b actual %b",
                   $realtime, want.last, last_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("bus_sniff_video_frame_builder_tb failed");
      $finish;
    end
  end

  initial begin
    bsvfb_pkg::cfg_t c;
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid_i = 1'b0; start_of_frame_i = 1'b0;
    frame_number_i = '0; bus_sample_i = 16'hFFFF;
    shadow = '{1'b0, 1'b1, bsvfb_pkg::CfgResetCasMin, bsvfb_pkg::CfgResetCasMax,
               bsvfb_pkg::CfgResetIoMin, bsvfb_pkg::CfgResetIoMax,
               bsvfb_pkg::CfgResetSettle};
    border_byte = '0;
    flash_on = 1'b0;
    clear_frame();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    verify_cfg();

    c = '{1'b0, 1'b1, 6'd1, 6'd2, 6'd1, 6'd2, 6'd0};
    apply_cfg(c);
    foreach (probe_rows[i]) begin
      push_sample(probe_rows[i].sof, probe_rows[i].fn, probe_rows[i].bus,
                  !probe_rows[i].typed);
      if (probe_rows[i].typed) begin
        fb_writes.push_back('{probe_rows[i].addr, probe_rows[i].colour, 1'b1});
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      settle_pipe();
      apply_cfg(phase_cfg[p]);
      if (p == 0) hold_req = 1'b1;
      run_phase(phase_len[p], phase_long[p]);
    end

    // closing stretch with no idling on either side
    settle_pipe();
    idle_on = 1'b0;
    c = '{1'($urandom), 1'($urandom), 6'd2, 6'd2, 6'd4, 6'd4, 6'd10};
    apply_cfg(c);
    run_phase(FinalLen, 1'b0);
    in_valid_i <= 1'b0;

    while (fb_writes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("bus_sniff_video_frame_builder_tb passed");
    end else begin
      $display("bus_sniff_video_frame_builder_tb failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/bsvfb_pkg.sv
rtl/bsvfb_front.sv
rtl/bsvfb_fifo.sv
rtl/bsvfb_back.sv
rtl/bus_sniff_video_frame_builder.sv
tb/bus_sniff_video_frame_builder_tb.sv
